FILE: rtl/core/npcm_pkg.sv
// Shared types, constants and helpers of the nearest palette color match block.
package npcm_pkg;

  // Palette geometry
  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int SIZE_W        = 9;
  localparam int CHAN_W        = 16;
  localparam int DIST_W        = 18;
  localparam int IDX_OUT_W     = 8;

  // Running best starts above every reachable distance
  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(3 * 65536);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MATCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } npcm_state_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } npcm_color_t;

  // Scan control from the sequencer to the best-entry tracker
  typedef struct packed {
    logic              start;
    logic              rd_vld;
    logic [ADDR_W-1:0] rd_idx;
  } npcm_scan_t;

  // Tracker status and running best entry
  typedef struct packed {
    logic              busy;
    logic [ADDR_W-1:0] idx;
    npcm_color_t       color;
    logic [DIST_W-1:0] distance;
  } npcm_best_t;

  function automatic logic [CHAN_W-1:0] abs_diff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: rtl/core/npcm_in_if.sv
// Input item channel: palette writes and match queries.
interface npcm_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  entry_index;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;

  modport source (output valid, cmd, entry_index, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, cmd, entry_index, red_in, green_in, blue_in, output ready);
endinterface

FILE: rtl/core/npcm_out_if.sv
// Result item channel: nearest entry, its color and its distance.
interface npcm_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [7:0]  match_index;
  logic [15:0] match_red;
  logic [15:0] match_green;
  logic [15:0] match_blue;
  logic [17:0] distance;

  modport source (output valid, found, match_index, match_red, match_green, match_blue,
                  distance, input ready);
  modport sink   (input valid, found, match_index, match_red, match_green, match_blue,
                  distance, output ready);
endinterface

FILE: rtl/core/npcm_cfg_if.sv
// Configuration write channel carrying the palette size.
interface npcm_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/nearest_palette_color_match_top.sv
// Top level of the nearest palette color match block: sequencer, palette memory, result register.
//
// A write item stores one 48-bit palette entry in a single-port synchronous memory and
// returns a result with found clear through the finish state. A match item reads entries
// 0 to n-1, where n is palette_size capped at the memory depth, one entry per cycle through
// the single memory read port; each entry passes the registered memory read, the
// distance stage and the compare stage, and the result is loaded once they drain. When
// n is zero, no entry is read. A new item is taken while the previous result still waits in
// the output register; a result that cannot enter the output register holds the block.
// Palette entries must be written before any match covers them. The memory needs no
// clearing pass after reset. Write the palette size only while no item is in flight.
module nearest_palette_color_match_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  npcm_in_if.sink     in_i,
  npcm_out_if.source  out_o,
  npcm_cfg_if.sink    cfg_i
);

  npcm_pkg::npcm_state_e         state_q, state_d;
  logic [npcm_pkg::SIZE_W-1:0]   size_q;

  logic                          cmd_q;
  logic                          empty_q;
  npcm_pkg::npcm_color_t         query_q;
  logic [npcm_pkg::ADDR_W-1:0]   last_q;
  logic [npcm_pkg::ADDR_W-1:0]   rd_addr_q;
  logic                          rd_vld_q;
  logic [npcm_pkg::ADDR_W-1:0]   rd_idx_q;
  npcm_pkg::npcm_color_t         rd_data_q;

  npcm_pkg::npcm_color_t         palette_mem [npcm_pkg::PALETTE_DEPTH];

  logic                          in_fire;
  logic                          mem_we;
  logic                          rd_en;
  logic                          load_out;
  logic                          scan_start;
  logic [31:0]                   n_eff;

  npcm_pkg::npcm_scan_t          scan;
  npcm_pkg::npcm_best_t          best;

  logic                          out_valid_q;
  logic                          found_q;
  logic [npcm_pkg::IDX_OUT_W-1:0] match_index_q;
  npcm_pkg::npcm_color_t         match_color_q;
  logic [npcm_pkg::DIST_W-1:0]   distance_q;

  // Accept configuration at any time; the user must write only while idle, the block does not enforce it
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= npcm_pkg::SIZE_RESET;
    end else if (cfg_i.valid) begin
      size_q <= cfg_i.data;
    end
  end

  // Cap the searched count at the memory depth
  assign n_eff = (32'(size_q) > npcm_pkg::PALETTE_DEPTH) ? npcm_pkg::PALETTE_DEPTH
                                                         : 32'(size_q);

  assign in_fire    = in_i.valid && in_i.ready;
  assign mem_we     = in_fire && (in_i.cmd == npcm_pkg::CMD_WRITE) &&
                      (32'(in_i.entry_index) < npcm_pkg::PALETTE_DEPTH);
  assign scan_start = in_fire && (in_i.cmd == npcm_pkg::CMD_MATCH);

  // Sequence writes and scans; writes happen only while idle, so no read overlaps them
  always_comb begin
    state_d    = state_q;
    in_i.ready = 1'b0;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      npcm_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if ((in_i.cmd == npcm_pkg::CMD_MATCH) && (n_eff != 32'd0)) begin
            state_d = npcm_pkg::ST_SCAN;
          end else begin
            state_d = npcm_pkg::ST_FINISH;
          end
        end
      end
      npcm_pkg::ST_SCAN: begin
        rd_en = 1'b1;
        if (rd_addr_q == last_q) begin
          state_d = npcm_pkg::ST_DRAIN;
        end
      end
      npcm_pkg::ST_DRAIN: begin
        if (!rd_vld_q && !best.busy) begin
          state_d = npcm_pkg::ST_FINISH;
        end
      end
      npcm_pkg::ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = npcm_pkg::ST_IDLE;
        end
      end
      default: state_d = npcm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= npcm_pkg::ST_IDLE;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
    end
  end

  // Latch the item and reset the scan address, then step the address on each scan read
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q     <= in_i.cmd;
      empty_q   <= (n_eff == 32'd0);
      query_q   <= '{red: in_i.red_in, green: in_i.green_in, blue: in_i.blue_in};
      last_q    <= npcm_pkg::ADDR_W'(n_eff - 32'd1);
      rd_addr_q <= '0;
    end else if (rd_en) begin
      rd_addr_q <= rd_addr_q + npcm_pkg::ADDR_W'(1);
    end
  end

  // Palette memory: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      palette_mem[npcm_pkg::ADDR_W'(in_i.entry_index)] <=
        '{red: in_i.red_in, green: in_i.green_in, blue: in_i.blue_in};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= palette_mem[rd_addr_q];
      rd_idx_q  <= rd_addr_q;
    end
  end

  assign scan.start  = scan_start;
  assign scan.rd_vld = rd_vld_q;
  assign scan.rd_idx = rd_idx_q;

  npcm_best u_best (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .scan_i    (scan),
    .rd_data_i (rd_data_q),
    .query_i   (query_q),
    .best_o    (best)
  );

  // Hold the result until the sink takes the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if ((cmd_q == npcm_pkg::CMD_MATCH) && !empty_q) begin
        found_q       <= 1'b1;
        match_index_q <= npcm_pkg::IDX_OUT_W'(best.idx);
        match_color_q <= best.color;
        distance_q    <= best.distance;
      end else begin
        found_q       <= 1'b0;
        match_index_q <= '0;
        match_color_q <= '0;
        distance_q    <= '0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = found_q;
  assign out_o.match_index = match_index_q;
  assign out_o.match_red   = match_color_q.red;
  assign out_o.match_green = match_color_q.green;
  assign out_o.match_blue  = match_color_q.blue;
  assign out_o.distance    = distance_q;

  // A palette write never coincides with a scan read
  a_no_write_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && rd_en))
    else $error("palette write during scan read");

  // Read data is valid only the cycle after a scan read
  a_rd_vld_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == npcm_pkg::ST_SCAN))
    else $error("read data valid without a scan read");

  // A finished non-empty match has a best distance below the start value
  a_match_has_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && (cmd_q == npcm_pkg::CMD_MATCH) && !empty_q) |->
      (best.distance < npcm_pkg::DIST_START))
    else $error("match finished without a best entry");

  // The pipeline is empty whenever a result is loaded
  a_drained_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!rd_vld_q && !best.busy))
    else $error("result loaded with scan still in flight");

endmodule

FILE: rtl/core/npcm_best.sv
// Distance pipeline and running best-entry tracker for the palette scan.
module npcm_best (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  npcm_pkg::npcm_scan_t  scan_i,
  input  npcm_pkg::npcm_color_t rd_data_i,
  input  npcm_pkg::npcm_color_t query_i,
  output npcm_pkg::npcm_best_t  best_o
);

  logic                          vld1_q;
  logic [npcm_pkg::ADDR_W-1:0]   idx1_q;
  npcm_pkg::npcm_color_t         color1_q;
  logic [npcm_pkg::DIST_W-1:0]   dist1_d, dist1_q;

  logic [npcm_pkg::ADDR_W-1:0]   best_idx_q;
  npcm_pkg::npcm_color_t         best_color_q;
  logic [npcm_pkg::DIST_W-1:0]   best_dist_q;

  // Sum the absolute channel differences of the entry just read
  always_comb begin
    dist1_d = npcm_pkg::DIST_W'(npcm_pkg::abs_diff(query_i.red,   rd_data_i.red))
            + npcm_pkg::DIST_W'(npcm_pkg::abs_diff(query_i.green, rd_data_i.green))
            + npcm_pkg::DIST_W'(npcm_pkg::abs_diff(query_i.blue,  rd_data_i.blue));
  end

  // Stage the distance with its entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= scan_i.rd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_i.rd_vld) begin
      idx1_q   <= scan_i.rd_idx;
      color1_q <= rd_data_i;
      dist1_q  <= dist1_d;
    end
  end

  // Replace the best only on a strictly smaller distance, so ties keep the lowest index
  always_ff @(posedge clk_i) begin
    if (scan_i.start) begin
      best_dist_q <= npcm_pkg::DIST_START;
      best_idx_q  <= '0;
    end else if (vld1_q && (dist1_q < best_dist_q)) begin
      best_dist_q  <= dist1_q;
      best_idx_q   <= idx1_q;
      best_color_q <= color1_q;
    end
  end

  assign best_o.busy     = vld1_q;
  assign best_o.idx      = best_idx_q;
  assign best_o.color    = best_color_q;
  assign best_o.distance = best_dist_q;

endmodule

FILE: verif/tb_nearest_palette_color_match_top.sv
// Testbench for the nearest palette color match block: palette writes, searches and size updates.
`timescale 1ns / 100ps

module tb_nearest_palette_color_match_top;
  import npcm_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 6;
  localparam int MAX_CYCLES      = 1_200_000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int QUIET_CYCLES    = 8;
  localparam int END_SETTLE      = 300;
  localparam int PHASE_ITEMS     = 34;
  localparam int MAX_REPORTS     = 60;
  localparam int unsigned FAR_DIST = 3 * 65536;

  localparam npcm_color_t C_BLACK = '{red: 16'h0000, green: 16'h0000, blue: 16'h0000};
  localparam npcm_color_t C_WHITE = '{red: 16'hFFFF, green: 16'hFFFF, blue: 16'hFFFF};
  localparam npcm_color_t C_GREY  = '{red: 16'h8000, green: 16'h8000, blue: 16'h8000};
  localparam npcm_color_t C_MIX   = '{red: 16'hFFFF, green: 16'h0000, blue: 16'h8000};

  typedef struct packed {
    logic                  cmd;
    logic [ADDR_W-1:0]     entry_index;
    npcm_color_t           color;
  } palette_item_t;

  typedef struct packed {
    logic                  found;
    logic [IDX_OUT_W-1:0]  idx;
    npcm_color_t           color;
    logic [DIST_W-1:0]     distance;
  } palette_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  npcm_in_if  in_if ();
  npcm_out_if out_if ();
  npcm_cfg_if cfg_if ();

  nearest_palette_color_match_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Mirror of the palette and the size register
  npcm_color_t        pal_mirror [PALETTE_DEPTH];
  logic [SIZE_W-1:0]  size_mirror;
  palette_reply_t     replies_q [$];
  int                 err_count;
  int unsigned        cycle_count;
  bit                 send_gaps_on;
  bit                 hold_off_req;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("%0t: watchdog expired after %0d cycles", $time, cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned chan_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    return (a >= b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic int unsigned searched_count();
    return (size_mirror > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(size_mirror);
  endfunction

  // Update the mirror and compute the reply of one transaction
  function automatic palette_reply_t apply_palette_item(palette_item_t it);
    palette_reply_t r;
    int unsigned best;
    int unsigned sum;
    r = '0;
    if (it.cmd == CMD_WRITE) begin
      if (it.entry_index < PALETTE_DEPTH) pal_mirror[it.entry_index] = it.color;
      return r;
    end
    best = FAR_DIST;
    for (int unsigned i = 0; i < searched_count(); i++) begin
      sum = chan_gap(it.color.red, pal_mirror[i].red)
          + chan_gap(it.color.green, pal_mirror[i].green)
          + chan_gap(it.color.blue, pal_mirror[i].blue);
      // Only a strictly smaller sum wins, so ties keep the lowest index
      if (sum < best) begin
        best       = sum;
        r.found    = 1'b1;
        r.idx      = i[IDX_OUT_W-1:0];
        r.color    = pal_mirror[i];
        r.distance = sum[DIST_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CHAN_W-1:0] extreme_chan();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic npcm_color_t rand_color();
    npcm_color_t c;
    c.red   = CHAN_W'($urandom);
    c.green = CHAN_W'($urandom);
    c.blue  = CHAN_W'($urandom);
    return c;
  endfunction

  // Mix fresh colors, duplicates of other entries (ties) and corner values
  function automatic npcm_color_t pick_entry_color();
    int unsigned r;
    npcm_color_t c;
    r = $urandom_range(0, 99);
    if (r < 40) return rand_color();
    if (r < 70) return pal_mirror[$urandom_range(0, PALETTE_DEPTH - 1)];
    c.red   = extreme_chan();
    c.green = extreme_chan();
    c.blue  = extreme_chan();
    return c;
  endfunction

  // Queries land mostly near or on entries in the searched range
  function automatic npcm_color_t pick_query(int unsigned span);
    int unsigned r;
    npcm_color_t c;
    r = $urandom_range(0, 99);
    if (r < 35 || span == 0) return rand_color();
    c = pal_mirror[$urandom_range(0, span - 1)];
    if (r < 75) begin
      c.red   = c.red + CHAN_W'($urandom_range(0, 32)) - CHAN_W'(16);
      c.green = c.green + CHAN_W'($urandom_range(0, 32)) - CHAN_W'(16);
      c.blue  = c.blue + CHAN_W'($urandom_range(0, 32)) - CHAN_W'(16);
    end else if (r >= 90) begin
      c.red   = extreme_chan();
      c.green = extreme_chan();
      c.blue  = extreme_chan();
    end
    return c;
  endfunction

  function automatic palette_item_t make_write(logic [ADDR_W-1:0] idx, npcm_color_t c);
    palette_item_t it;
    it.cmd         = CMD_WRITE;
    it.entry_index = idx;
    it.color       = c;
    return it;
  endfunction

  function automatic palette_item_t make_match(npcm_color_t c);
    palette_item_t it;
    it.cmd         = CMD_MATCH;
    it.entry_index = ADDR_W'($urandom);
    it.color       = c;
    return it;
  endfunction

  function automatic palette_item_t random_item(int unsigned span);
    if ($urandom_range(0, 99) < 30)
      return make_write(ADDR_W'($urandom_range(0, PALETTE_DEPTH - 1)), pick_entry_color());
    return make_match(pick_query(span));
  endfunction

  // Offer one transaction after an optional gap and record its reply
  task automatic send_item(palette_item_t it);
    int unsigned gap;
    gap = (send_gaps_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid       <= 1'b1;
    in_if.cmd         <= it.cmd;
    in_if.entry_index <= it.entry_index;
    in_if.red_in      <= it.color.red;
    in_if.green_in    <= it.color.green;
    in_if.blue_in     <= it.color.blue;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    replies_q.push_back(apply_palette_item(it));
  endtask

  // Drop valid and wait until every reply has come back
  task automatic wait_quiet();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (replies_q.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_palette_size(logic [SIZE_W-1:0] val);
    wait_quiet();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    size_mirror = val;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Empty palette: searches find nothing, writes still land
  task automatic test_empty_palette();
    set_palette_size('0);
    send_item(make_match(C_BLACK));
    send_item(make_match(C_WHITE));
    send_item(make_write(8'd0, C_BLACK));
    send_item(make_write(8'd1, C_WHITE));
    send_item(make_write(8'd2, C_MIX));
    send_item(make_write(8'd3, C_WHITE));
    send_item(make_write(8'hFF, rand_color()));
    send_item(make_match(C_GREY));
  endtask

  // Exact hits, largest distance and ties on duplicate entries
  task automatic test_nearest_entry();
    set_palette_size(SIZE_W'(1));
    send_item(make_match(C_WHITE));
    set_palette_size(SIZE_W'(4));
    send_item(make_match(C_BLACK));
    send_item(make_match(C_WHITE));
    send_item(make_match(C_GREY));
    send_item(make_match(C_MIX));
    set_palette_size(SIZE_W'(2));
    send_item(make_match(C_MIX));
    send_item(make_match(C_GREY));
  endtask

  // Fill every entry, then search the whole palette and a size above depth
  task automatic test_full_palette();
    send_gaps_on = 1'b1;
    for (int i = 0; i < PALETTE_DEPTH; i++)
      send_item(make_write(ADDR_W'(i), pick_entry_color()));
    set_palette_size(SIZE_W'(PALETTE_DEPTH));
    repeat (4) send_item(make_match(pick_query(searched_count())));
    set_palette_size('1);
    repeat (4) send_item(make_match(pick_query(searched_count())));
  endtask

  // Stall the result side long enough to back up the input
  task automatic test_output_hold_off();
    set_palette_size(SIZE_W'(3));
    send_gaps_on = 1'b0;
    hold_off_req = 1'b1;
    repeat (14) send_item(random_item(searched_count()));
  endtask

  task automatic test_random_phases();
    int unsigned plan [12];
    plan = '{1, 2, 7, 16, 511, 0, 40, 256, 3, 0, 0, 257};
    plan[9]  = $urandom_range(0, 511);
    plan[10] = $urandom_range(0, 63);
    foreach (plan[p]) begin
      set_palette_size(SIZE_W'(plan[p]));
      send_gaps_on = ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) send_item(random_item(searched_count()));
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Compare each accepted reply with the oldest one predicted
  always @(posedge clk_i) begin : result_check
    palette_reply_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (replies_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected reply, expected none, actual index 0x%0h", $time,
                   out_if.match_index);
      end else begin
        want = replies_q.pop_front();
        check_field("found", want.found, out_if.found);
        check_field("match_index", want.idx, out_if.match_index);
        check_field("match_red", want.color.red, out_if.match_red);
        check_field("match_green", want.color.green, out_if.match_green);
        check_field("match_blue", want.color.blue, out_if.match_blue);
        check_field("distance", want.distance, out_if.distance);
      end
    end
  end

  // Drive ready: random stalls in stretches, plus the requested long hold-off
  initial begin : result_sink
    int unsigned hold_cnt;
    int unsigned stall_cnt;
    int unsigned stretch_cnt;
    bit stalls_on;
    bit stalled;
    hold_cnt    = 0;
    stall_cnt   = 0;
    stretch_cnt = 0;
    stalls_on   = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stretch_cnt == 0) begin
        stretch_cnt = $urandom_range(50, 300);
        stalls_on   = ($urandom_range(0, 2) != 0);
      end else begin
        stretch_cnt--;
      end
      if (hold_off_req) begin
        hold_cnt     = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_cnt == 0 && stall_cnt == 0 && stalls_on && $urandom_range(0, 99) < 20)
        stall_cnt = idle_len();
      stalled = (hold_cnt != 0) || (stall_cnt != 0);
      if (hold_cnt != 0) hold_cnt--;
      else if (stall_cnt != 0) stall_cnt--;
      out_if.ready <= !stalled;
    end
  end

  initial begin
    foreach (pal_mirror[i]) pal_mirror[i] = '0;
    size_mirror  = SIZE_RESET;
    err_count    = 0;
    cycle_count  = 0;
    send_gaps_on = 1'b1;
    hold_off_req = 1'b0;
    rst_ni       = 1'b0;
    in_if.valid       = 1'b0;
    in_if.cmd         = CMD_WRITE;
    in_if.entry_index = '0;
    in_if.red_in      = '0;
    in_if.green_in    = '0;
    in_if.blue_in     = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_palette();
    test_nearest_entry();
    test_full_palette();
    test_output_hold_off();
    test_random_phases();

    // Drain outstanding replies and let the pipeline settle
    wait_quiet();
    repeat (END_SETTLE) @(posedge clk_i);
    if (err_count == 0 && replies_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/npcm_pkg.sv
rtl/core/npcm_in_if.sv
rtl/core/npcm_out_if.sv
rtl/core/npcm_cfg_if.sv
rtl/core/npcm_best.sv
rtl/core/nearest_palette_color_match_top.sv
verif/tb_nearest_palette_color_match_top.sv
